// ----- design/ffba_pkg.sv -----
// Shared types and constants for the first-fit block allocator.
// No dependencies; used by every module of the block.
package ffba_pkg;

    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 25;
    localparam int REQ_W   = 24;
    localparam int HDR_W   = 8;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Register indexes (byte address is 4 * index)
    localparam logic [1:0] REG_HEAP_BASE    = 2'd0;
    localparam logic [1:0] REG_HEAP_SIZE    = 2'd1;
    localparam logic [1:0] REG_HEADER_BYTES = 2'd2;

    localparam logic [ADDR_W-1:0] HEAP_BASE_RST    = 32'd0;
    localparam logic [ADDR_W-1:0] HEAP_SIZE_RST    = 32'd1048576;
    localparam logic [HDR_W-1:0]  HEADER_BYTES_RST = 8'd24;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_NULL_FREE = 2'd2,
        ST_UNKNOWN   = 2'd3
    } status_t;

    typedef struct packed {
        logic              op;
        logic [REQ_W-1:0]  request_bytes;
        logic [ADDR_W-1:0] block_address;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] payload_address;
        logic              reused;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] heap_base;
        logic [ADDR_W-1:0] heap_size;
        logic [HDR_W-1:0]  header_bytes;
    } cfg_t;

    // Request as seen by the cells
    typedef struct packed {
        logic              op;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr_rel;
    } cmd_t;

    // Packet walking down the cell row
    typedef struct packed {
        logic              tok;
        logic              found;
        logic [ADDR_W-1:0] found_offset;
        logic [ADDR_W-1:0] last_offset;
        logic [SIZE_W-1:0] last_size;
    } pkt_t;

    // Table update broadcast at the end of a request
    typedef struct packed {
        logic              clr_free;
        logic              set_free;
        logic              append;
        logic [ADDR_W-1:0] app_offset;
        logic [SIZE_W-1:0] app_size;
    } commit_t;

endpackage

// ----- design/ffba_cell.sv -----
// One table entry of the allocator plus its stage of the search row.
// Depends on ffba_pkg.
module ffba_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CW-1:0]     count,
    input  ffba_pkg::cmd_t    cmd,
    input  ffba_pkg::commit_t commit,
    input  ffba_pkg::pkt_t    pkt_in,
    output ffba_pkg::pkt_t    pkt_out
);
    import ffba_pkg::*;

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [ADDR_W-1:0] offset_reg;
    logic [SIZE_W-1:0] size_reg;
    logic              free_reg;
    logic              hit_reg;
    logic              hit_next;
    pkt_t              pkt_reg;
    pkt_t              pkt_next;
    logic              live;
    logic              is_last;
    logic              match;
    logic              claim;

    assign live    = MY_IDX < count;
    // count of zero wraps to all ones, which is never a cell index
    assign is_last = MY_IDX == (count - CW'(1));
    assign match   = (cmd.op == OP_ALLOC) ? (free_reg && (size_reg >= cmd.size))
                                          : (offset_reg == cmd.addr_rel);
    assign claim   = pkt_in.tok && !pkt_in.found && live && match;

    always_comb
    begin
        pkt_next = pkt_in;
        if (claim)
        begin
            pkt_next.found        = 1'b1;
            pkt_next.found_offset = offset_reg;
        end
        if (pkt_in.tok && is_last)
        begin
            pkt_next.last_offset = offset_reg;
            pkt_next.last_size   = size_reg;
        end
        hit_next = pkt_in.tok ? claim : hit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            pkt_reg <= pkt_next;
            hit_reg <= hit_next;
        end
    end

    // entry storage, written by append or by a free-mark update on the hit cell
    always_ff @(posedge clk)
    begin
        if (commit.append && (MY_IDX == count))
        begin
            offset_reg <= commit.app_offset;
            size_reg   <= commit.app_size;
            free_reg   <= 1'b0;
        end
        else if (hit_reg && commit.clr_free)
        begin
            free_reg <= 1'b0;
        end
        else if (hit_reg && commit.set_free)
        begin
            free_reg <= 1'b1;
        end
    end

    assign pkt_out = pkt_reg;

endmodule

// ----- design/ffba_regs.sv -----
// APB-style configuration registers of the allocator.
// Depends on ffba_pkg.
module ffba_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ffba_pkg::PADDR_W-1:0]  paddr,
    input  logic [ffba_pkg::PDATA_W-1:0]  pwdata,
    output logic [ffba_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output ffba_pkg::cfg_t                cfg
);
    import ffba_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_HEAP_BASE:    cfg_next.heap_base    = pwdata;
                REG_HEAP_SIZE:    cfg_next.heap_size    = pwdata;
                REG_HEADER_BYTES: cfg_next.header_bytes = pwdata[HDR_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_HEAP_BASE:    prdata = cfg_reg.heap_base;
            REG_HEAP_SIZE:    prdata = cfg_reg.heap_size;
            REG_HEADER_BYTES: prdata = PDATA_W'(cfg_reg.header_bytes);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heap_base    <= HEAP_BASE_RST;
            cfg_reg.heap_size    <= HEAP_SIZE_RST;
            cfg_reg.header_bytes <= HEADER_BYTES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule

// ----- design/first_fit_block_allocator.sv -----
// First-fit block allocator: top level with control, heap top and cell row.
// The result follows the search token's walk through the full cell row; a new request is
// taken only in the idle state, after the previous response has been registered.
// Reset: table empty (entry count 0), heap top 0, registers at their defaults;
// entry storage itself is not cleared and needs no clearing pass.
// Depends on ffba_pkg, ffba_cell, ffba_regs.
module first_fit_block_allocator #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          req_valid,
    output logic                          req_ready,
    input  ffba_pkg::req_t                req,
    // response channel
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output ffba_pkg::rsp_t                rsp,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ffba_pkg::PADDR_W-1:0]  paddr,
    input  logic [ffba_pkg::PDATA_W-1:0]  pwdata,
    output logic [ffba_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import ffba_pkg::*;

    localparam int              CW         = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0]   FULL_COUNT = CW'(MAX_BLOCKS);
    localparam int              TOP_W      = ADDR_W + 2;
    localparam int              DROP_W     = SIZE_W + 1;

    // one-hot control states
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    cfg_t                cfg;
    state_t              state_reg;
    state_t              state_next;
    logic                start_reg;
    cmd_t                cmd_reg;
    cmd_t                cmd_next;
    logic                null_reg;
    pkt_t                end_reg;
    logic [TOP_W-1:0]    top_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [ADDR_W-1:0]   heap_used_reg;
    logic [ADDR_W-1:0]   heap_used_next;
    rsp_t                rsp_reg;
    rsp_t                rsp_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    commit_t             commit;
    pkt_t                chain [0:MAX_BLOCKS];

    logic                req_xfer;
    logic                fire;
    logic [SIZE_W-1:0]   round_sum;
    logic                last_hit;
    logic [DROP_W-1:0]   drop;
    logic [ADDR_W-1:0]   app_offset;
    logic [ADDR_W-1:0]   grant_offset;

    ffba_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // token enters cell 0 the cycle after the request transfer
    always_comb
    begin
        chain[0]     = '0;
        chain[0].tok = start_reg;
    end

    for (genvar g = 0; g < MAX_BLOCKS; g++)
    begin : g_cell
        ffba_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .count   (count_reg),
            .cmd     (cmd_reg),
            .commit  (commit),
            .pkt_in  (chain[g]),
            .pkt_out (chain[g+1])
        );
    end

    assign req_ready = (state_reg == S_IDLE);
    assign req_xfer  = req_valid && req_ready;
    assign fire      = (state_reg == S_FINISH) && (!rsp_valid_reg || rsp_ready);

    // size rounded up to a multiple of 4
    assign round_sum = {1'b0, req.request_bytes} + SIZE_W'(3);

    always_comb
    begin
        cmd_next = cmd_reg;
        if (req_xfer)
        begin
            cmd_next.op       = req.op;
            cmd_next.size     = {round_sum[SIZE_W-1:2], 2'b00};
            // compare offsets against the address relative to the heap base
            cmd_next.addr_rel = req.block_address - cfg.heap_base;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (chain[MAX_BLOCKS].tok)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // end-of-walk decision
    assign last_hit     = (count_reg != '0) && (end_reg.last_offset == cmd_reg.addr_rel);
    assign drop         = DROP_W'(cfg.header_bytes) + DROP_W'(end_reg.last_size);
    assign app_offset   = heap_used_reg + ADDR_W'(cfg.header_bytes);
    assign grant_offset = end_reg.found ? end_reg.found_offset : app_offset;

    always_comb
    begin
        commit            = '0;
        commit.app_offset = app_offset;
        commit.app_size   = cmd_reg.size;
        count_next        = count_reg;
        heap_used_next    = heap_used_reg;
        rsp_next          = rsp_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp_ready;

        if (fire)
        begin
            rsp_valid_next           = 1'b1;
            rsp_next.status          = ST_DONE;
            rsp_next.payload_address = '0;
            rsp_next.reused          = 1'b0;
            if (cmd_reg.op == OP_ALLOC)
            begin
                if (end_reg.found)
                begin
                    commit.clr_free          = 1'b1;
                    rsp_next.payload_address = cfg.heap_base + grant_offset;
                    rsp_next.reused          = 1'b1;
                end
                else if (count_reg == FULL_COUNT)
                begin
                    rsp_next.status = ST_NO_SPACE;
                end
                else if (top_reg > TOP_W'(cfg.heap_size))
                begin
                    rsp_next.status = ST_NO_SPACE;
                end
                else
                begin
                    commit.append            = 1'b1;
                    count_next               = count_reg + CW'(1);
                    heap_used_next           = top_reg[ADDR_W-1:0];
                    rsp_next.payload_address = cfg.heap_base + grant_offset;
                end
            end
            else
            begin
                if (null_reg)
                begin
                    rsp_next.status = ST_NULL_FREE;
                end
                else if (last_hit)
                begin
                    // last block goes away and the heap top drops, floor at zero
                    count_next = count_reg - CW'(1);
                    if (ADDR_W'(drop) > heap_used_reg)
                    begin
                        heap_used_next = '0;
                    end
                    else
                    begin
                        heap_used_next = heap_used_reg - ADDR_W'(drop);
                    end
                end
                else if (end_reg.found)
                begin
                    commit.set_free = 1'b1;
                end
                else
                begin
                    rsp_next.status = ST_UNKNOWN;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            count_reg     <= '0;
            heap_used_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= req_xfer;
            count_reg     <= count_next;
            heap_used_reg <= heap_used_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        rsp_reg <= rsp_next;
        if (req_xfer)
        begin
            null_reg <= (req.block_address == '0);
        end
        if (chain[MAX_BLOCKS].tok)
        begin
            end_reg <= chain[MAX_BLOCKS];
        end
        // new heap top if this request appends; settles long before the walk ends
        top_reg <= TOP_W'(heap_used_reg) + TOP_W'(cfg.header_bytes) + TOP_W'(cmd_reg.size);
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
